// ----- rtl/core/atsc_pkg.sv -----
// Shared types, token kind codes, byte codes and byte class helpers
// for the assembly token scanner. No dependencies.
package atsc_pkg;

    localparam int RESULT_KIND_BITS = 6;
    localparam int REG_INDEX_BITS   = 5;
    localparam int FIELD_BITS       = 16;

    // Token kinds
    localparam logic [5:0] KIND_EOF       = 6'd0;
    localparam logic [5:0] KIND_DOT       = 6'd1;
    localparam logic [5:0] KIND_COMMA     = 6'd2;
    localparam logic [5:0] KIND_COLON     = 6'd3;
    localparam logic [5:0] KIND_MINUS     = 6'd4;
    localparam logic [5:0] KIND_LPAREN    = 6'd5;
    localparam logic [5:0] KIND_RPAREN    = 6'd6;
    localparam logic [5:0] KIND_IDENT     = 6'd7;
    localparam logic [5:0] KIND_NUMBER    = 6'd8;
    localparam logic [5:0] KIND_STRING    = 6'd9;
    localparam logic [5:0] KIND_MNEM_BASE = 6'd10;
    localparam logic [5:0] KIND_REGISTER  = 6'd34;

    // Byte codes
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_3       = 8'h33;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    // Mnemonics, first byte most significant; kind is KIND_MNEM_BASE + index
    localparam int MNEM_COUNT = 24;
    localparam logic [31:0] MNEM_CODE [MNEM_COUNT] = '{
        "add", "sub", "and", "or", "xor",
        "addi", "andi", "ori", "xori",
        "beq", "bne", "blt", "bge",
        "ld", "lw", "lh", "lb", "lwu", "lhu", "lbu",
        "sd", "sw", "sh", "sb"
    };
    localparam logic [2:0] MNEM_LEN [MNEM_COUNT] = '{
        3'd3, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd4, 3'd4, 3'd3, 3'd4,
        3'd3, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [4:0]  reg_index;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] lexeme_length;
    } atsc_result_t;

    // One request's worth of results from the scanner to the output queue
    typedef struct packed {
        logic         valid;
        logic         two;
        atsc_result_t res0;
        atsc_result_t res1;
    } atsc_push_t;

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return c inside {[CH_0:CH_9], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    // Single-byte punctuation; KIND_EOF when the byte is not punctuation
    function automatic logic [5:0] punct_kind(logic [7:0] c);
        logic [5:0] k;
        case (c)
            CH_DOT:    k = KIND_DOT;
            CH_COMMA:  k = KIND_COMMA;
            CH_COLON:  k = KIND_COLON;
            CH_MINUS:  k = KIND_MINUS;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/core/assembly_token_scanner.sv -----
// Assembly source tokenizer: one byte per request in, one token per result out.
// Depends on atsc_pkg, atsc_scanner, atsc_result_queue.
//
// Input channel s_*: one source byte per request (s_ch), or an end marker
// (s_end_of_input) that flushes any open number, word or string and emits EOF.
// Output channel m_*: token kind, register index, start line/column and length;
// m_last marks the final result caused by one request (at most two per request).
//
// Latency: a result is offered the cycle after the request that completes it,
// or later while results of earlier requests still wait in the queue.
// Throughput: one request per cycle while s_ready is high; the scanner state
// updates in combinational logic between its state registers and a two-entry
// result queue, and the queue hands out one result per cycle while m_ready is
// high, so requests that produce two results drain at one result per cycle.
// s_ready drops while both queue entries are occupied: when the receiver stalls
// on m_ready, or for one cycle when a request with two results is followed at
// once by another request that yields a result; no result is lost or repeated.
// Reset (aresetn low, synchronous): line and column return to 1, no token open,
// queue empty. An end-of-input request returns the scanner to the same state.
module assembly_token_scanner #(
    parameter int COUNTER_BITS = 16,
    parameter int KEY_CHARS    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_kind,
    output logic [4:0]  m_reg_index,
    output logic [15:0] m_start_line,
    output logic [15:0] m_start_column,
    output logic [15:0] m_lexeme_length,
    output logic        m_last
);
    import atsc_pkg::*;

    atsc_push_t   push;
    atsc_result_t out_res;
    logic         space;
    logic         accept;

    assign s_ready = space;
    assign accept  = s_valid && space;

    atsc_scanner #(
        .COUNTER_BITS (COUNTER_BITS),
        .KEY_CHARS    (KEY_CHARS)
    ) u_scanner (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .ch           (s_ch),
        .end_of_input (s_end_of_input),
        .push         (push)
    );

    atsc_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_res  (out_res),
        .out_last (m_last)
    );

    assign m_kind          = out_res.kind;
    assign m_reg_index     = out_res.reg_index;
    assign m_start_line    = out_res.start_line;
    assign m_start_column  = out_res.start_column;
    assign m_lexeme_length = out_res.lexeme_length;

    // Backpressure only comes from a full queue
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty result queue");

    // End of input always yields a result on the next cycle
    a_eof_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_input) |=> m_valid)
        else $error("end of input produced no result");

    // EOF is the final result of its request and has zero length
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_EOF) |-> (m_last && m_lexeme_length == 16'd0))
        else $error("EOF result malformed");

    // Register index only carried by register tokens
    a_reg_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_REGISTER) |-> (m_reg_index == 5'd0))
        else $error("nonzero register index on non-register token");

endmodule

// ----- rtl/core/atsc_scanner.sv -----
// Scanner state (mode, position, token under construction) and the
// combinational next-state / result logic. Depends on atsc_pkg.
module atsc_scanner #(
    parameter int COUNTER_BITS = 16,
    parameter int KEY_CHARS    = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         ch,
    input  logic               end_of_input,
    output atsc_pkg::atsc_push_t push
);
    import atsc_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int HB = 8 * KEY_CHARS;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_ZERO,
        MODE_DEC,
        MODE_BIN,
        MODE_OCT,
        MODE_HEX,
        MODE_STR,
        MODE_ESC,
        MODE_COMMENT
    } mode_t;

    typedef struct packed {
        logic [5:0] kind;
        logic [4:0] reg_index;
    } word_t;

    mode_t         mode_reg,  mode_next;
    logic [CB-1:0] line_reg,  line_next;
    logic [CB-1:0] col_reg,   col_next;
    logic [CB-1:0] start_reg, start_next;
    logic [CB-1:0] len_reg,   len_next;
    logic [HB-1:0] head_reg,  head_next;

    logic          more;
    logic          do_ext;
    logic          first_v;
    atsc_result_t  first_r;
    logic          punct_v;
    atsc_result_t  punct_r;
    logic [5:0]    pk;
    word_t         word;
    atsc_push_t    push_c;

    function automatic logic [CB-1:0] sat_inc(logic [CB-1:0] v);
        return (&v) ? v : v + CB'(1);
    endfunction

    function automatic logic [15:0] sat16(logic [CB-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (|w[31:16]) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic atsc_result_t make_res(logic [5:0] kind, logic [4:0] ri,
                                              logic [CB-1:0] line, logic [CB-1:0] col,
                                              logic [CB-1:0] len);
        atsc_result_t r;
        r.kind          = kind;
        r.reg_index     = ri;
        r.start_line    = sat16(line);
        r.start_column  = sat16(col);
        r.lexeme_length = sat16(len);
        return r;
    endfunction

    // Mnemonic / register / identifier decision from the buffered head bytes
    function automatic word_t classify_word(logic [HB-1:0] head, logic [CB-1:0] len);
        word_t      w;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [5:0] num;
        w.kind      = KIND_IDENT;
        w.reg_index = '0;
        b0  = head[23:16];
        b1  = head[15:8];
        b2  = head[7:0];
        num = 6'(b1[1:0]) * 6'd10 + 6'(b2[3:0]);
        if (len <= CB'(KEY_CHARS)) begin
            for (int i = 0; i < MNEM_COUNT; i++) begin
                if (w.kind == KIND_IDENT && len == CB'(MNEM_LEN[i])
                    && head == HB'(MNEM_CODE[i])) begin
                    w.kind = KIND_MNEM_BASE + 6'(i);
                end
            end
            if (w.kind == KIND_IDENT) begin
                if (len == CB'(2)) begin
                    if (b1 == CH_R && is_digit(b2)) begin
                        w.kind      = KIND_REGISTER;
                        w.reg_index = 5'(b2[3:0]);
                    end
                end else if (len == CB'(3)) begin
                    // two-digit register, no leading zero, at most 31
                    if (b0 == CH_R && b1 inside {[CH_1:CH_3]} && is_digit(b2)
                        && num <= 6'd31) begin
                        w.kind      = KIND_REGISTER;
                        w.reg_index = num[4:0];
                    end
                end
            end
        end
        return w;
    endfunction

    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        len_next   = len_reg;
        head_next  = head_reg;
        more       = 1'b1;
        do_ext     = 1'b0;
        first_v    = 1'b0;
        first_r    = '0;
        punct_v    = 1'b0;
        punct_r    = '0;
        pk         = punct_kind(ch);
        word       = classify_word(head_reg, len_reg);
        push_c     = '0;

        if (end_of_input) begin
            case (mode_reg)
                MODE_IDENT: begin
                    first_v = 1'b1;
                    first_r = make_res(word.kind, word.reg_index, line_reg,
                                       start_reg, len_reg);
                end
                MODE_ZERO, MODE_DEC, MODE_BIN, MODE_OCT, MODE_HEX: begin
                    first_v = 1'b1;
                    first_r = make_res(KIND_NUMBER, '0, line_reg, start_reg, len_reg);
                end
                MODE_STR, MODE_ESC: begin
                    first_v = 1'b1;
                    first_r = make_res(KIND_STRING, '0, line_reg, start_reg, len_reg);
                end
                default: ;
            endcase
            punct_v    = 1'b1;
            punct_r    = make_res(KIND_EOF, '0, line_reg, col_reg, '0);
            mode_next  = MODE_IDLE;
            line_next  = CB'(1);
            col_next   = CB'(1);
            start_next = '0;
            len_next   = '0;
            head_next  = '0;
        end else begin
            case (mode_reg)
                MODE_IDENT: begin
                    if (is_word(ch)) begin
                        do_ext = 1'b1;
                        more   = 1'b0;
                    end else begin
                        first_v   = 1'b1;
                        first_r   = make_res(word.kind, word.reg_index, line_reg,
                                             start_reg, len_reg);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_ZERO: begin
                    if (ch == CH_B) begin
                        do_ext = 1'b1; mode_next = MODE_BIN; more = 1'b0;
                    end else if (ch == CH_O) begin
                        do_ext = 1'b1; mode_next = MODE_OCT; more = 1'b0;
                    end else if (ch == CH_X) begin
                        do_ext = 1'b1; mode_next = MODE_HEX; more = 1'b0;
                    end else if (is_digit(ch)) begin
                        do_ext = 1'b1; mode_next = MODE_DEC; more = 1'b0;
                    end
                end
                MODE_DEC: begin
                    if (is_digit(ch)) begin
                        do_ext = 1'b1; more = 1'b0;
                    end
                end
                MODE_BIN: begin
                    if (ch inside {CH_0, CH_1}) begin
                        do_ext = 1'b1; more = 1'b0;
                    end
                end
                MODE_OCT: begin
                    if (ch inside {[CH_0:CH_7]}) begin
                        do_ext = 1'b1; more = 1'b0;
                    end
                end
                MODE_HEX: begin
                    if (is_hex(ch)) begin
                        do_ext = 1'b1; more = 1'b0;
                    end
                end
                MODE_STR: begin
                    // quotes take no column
                    if (ch == CH_QUOTE) begin
                        first_v   = 1'b1;
                        first_r   = make_res(KIND_STRING, '0, line_reg, start_reg, len_reg);
                        mode_next = MODE_IDLE;
                    end else begin
                        do_ext = 1'b1;
                        if (ch == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end
                    end
                    more = 1'b0;
                end
                MODE_ESC: begin
                    do_ext    = 1'b1;
                    mode_next = MODE_STR;
                    more      = 1'b0;
                end
                MODE_COMMENT: begin
                    if (ch == CH_NEWLINE) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        more = 1'b0;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase

            // number ended by a byte that cannot extend it
            if (more && mode_reg inside {MODE_ZERO, MODE_DEC, MODE_BIN, MODE_OCT, MODE_HEX})
            begin
                first_v   = 1'b1;
                first_r   = make_res(KIND_NUMBER, '0, line_reg, start_reg, len_reg);
                mode_next = MODE_IDLE;
            end

            if (do_ext) begin
                if (len_reg < CB'(KEY_CHARS)) begin
                    head_next = {head_reg[HB-9:0], ch};
                end
                len_next = sat_inc(len_reg);
                col_next = sat_inc(col_reg);
            end

            if (more) begin
                if (pk != KIND_EOF) begin
                    punct_v  = 1'b1;
                    punct_r  = make_res(pk, '0, line_reg, col_reg, CB'(1));
                    col_next = sat_inc(col_reg);
                end else if (is_alpha(ch) || ch == CH_UNDER || is_digit(ch)) begin
                    if (is_digit(ch)) begin
                        mode_next = (ch == CH_0) ? MODE_ZERO : MODE_DEC;
                    end else begin
                        mode_next = MODE_IDENT;
                    end
                    start_next = col_reg;
                    len_next   = CB'(1);
                    head_next  = HB'(ch);
                    col_next   = sat_inc(col_reg);
                end else if (ch == CH_QUOTE) begin
                    mode_next  = MODE_STR;
                    start_next = col_reg;
                    len_next   = '0;
                    head_next  = '0;
                end else if (ch == CH_NEWLINE) begin
                    line_next = sat_inc(line_reg);
                    col_next  = CB'(1);
                end else if (ch == CH_HASH) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    col_next = sat_inc(col_reg);
                end
            end
        end

        push_c.valid = accept && (first_v || punct_v);
        push_c.two   = first_v && punct_v;
        push_c.res0  = first_v ? first_r : punct_r;
        push_c.res1  = punct_r;
    end

    assign push = push_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= CB'(1);
            col_reg   <= CB'(1);
            start_reg <= '0;
            len_reg   <= '0;
            head_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            head_reg  <= head_next;
        end
    end

endmodule

// ----- rtl/core/atsc_result_queue.sv -----
// Two-entry result queue; each entry holds the one or two results of one request
// and hands them out one per cycle while m_ready is high. Depends on atsc_pkg.
module atsc_result_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  atsc_pkg::atsc_push_t   push,
    output logic                   space,
    output logic                   m_valid,
    input  logic                   m_ready,
    output atsc_pkg::atsc_result_t out_res,
    output logic                   out_last
);
    import atsc_pkg::*;

    typedef struct packed {
        logic         two;
        atsc_result_t res0;
        atsc_result_t res1;
    } entry_t;

    entry_t     entry_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       sub_reg,    sub_next;
    entry_t     head;
    logic       do_push;
    logic       do_pop;
    logic       take;

    assign head     = entry_reg[rd_ptr_reg];
    assign m_valid  = (count_reg != 2'd0);
    assign space    = (count_reg != 2'd2);
    assign out_res  = sub_reg ? head.res1 : head.res0;
    assign out_last = sub_reg || !head.two;
    assign take     = m_valid && m_ready;
    assign do_pop   = take && out_last;
    assign do_push  = push.valid && space;

    always_comb begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
        sub_next    = sub_reg;
        if (take) begin
            sub_next = !out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= '{two: push.two, res0: push.res0, res1: push.res1};
        end
    end

endmodule
